// File: hw/rtl/sps_pkg.sv
// Shared types, constants and decode helpers for the SPS syntax parser.
// Used by the other files in hw/rtl but sps_if; depends on nothing.
package sps_pkg;

  localparam int QDepth = 8;
  localparam int QPtrW  = $clog2(QDepth);

  // element kinds: 1..8 are fixed widths
  localparam logic [3:0] KIND_UE = 4'd0;
  localparam logic [3:0] KIND_SE = 4'd9;

  localparam logic [5:0] ID_PROFILE       = 6'd0;
  localparam logic [5:0] ID_SPS_ID        = 6'd9;
  localparam logic [5:0] ID_CHROMA        = 6'd10;
  localparam logic [5:0] ID_BIT_DEPTH_L   = 6'd12;
  localparam logic [5:0] ID_BIT_DEPTH_C   = 6'd13;
  localparam logic [5:0] ID_MATRIX_FLAG   = 6'd15;
  localparam logic [5:0] ID_LIST_PRESENT  = 6'd16;
  localparam logic [5:0] ID_LIST_ENTRY    = 6'd17;
  localparam logic [5:0] ID_LIST_FILL     = 6'd18;
  localparam logic [5:0] ID_LOG2_FRAME    = 6'd19;
  localparam logic [5:0] ID_POC_TYPE      = 6'd20;
  localparam logic [5:0] ID_LOG2_POC      = 6'd21;
  localparam logic [5:0] ID_DELTA_ZERO    = 6'd22;
  localparam logic [5:0] ID_POC_CYCLE     = 6'd25;
  localparam logic [5:0] ID_OFFSET_REF    = 6'd26;
  localparam logic [5:0] ID_REF_FRAMES    = 6'd27;
  localparam logic [5:0] ID_WIDTH         = 6'd29;
  localparam logic [5:0] ID_HEIGHT        = 6'd30;
  localparam logic [5:0] ID_FRAME_MBS     = 6'd31;
  localparam logic [5:0] ID_MBAFF         = 6'd32;
  localparam logic [5:0] ID_DIRECT_8X8    = 6'd33;
  localparam logic [5:0] ID_CROP_FLAG     = 6'd34;
  localparam logic [5:0] ID_CROP_LEFT     = 6'd35;
  localparam logic [5:0] ID_CROP_RIGHT    = 6'd36;
  localparam logic [5:0] ID_CROP_TOP      = 6'd37;
  localparam logic [5:0] ID_CROP_BOTTOM   = 6'd38;
  localparam logic [5:0] ID_VUI_FLAG      = 6'd39;
  localparam logic [5:0] ID_COUNT         = 6'd40;

  localparam logic [1:0] ERR_OK        = 2'd0;
  localparam logic [1:0] ERR_RANGE     = 2'd1;
  localparam logic [1:0] ERR_EXPGOLOMB = 2'd2;
  localparam logic [1:0] ERR_DELTA     = 2'd3;

  localparam logic [2:0] CFG_MAX_REF    = 3'd0;
  localparam logic [2:0] CFG_MAX_WIDTH  = 3'd1;
  localparam logic [2:0] CFG_MAX_HEIGHT = 3'd2;
  localparam logic [2:0] CFG_MAX_CROP_H = 3'd3;
  localparam logic [2:0] CFG_MAX_CROP_V = 3'd4;

  localparam logic [4:0] MaxPrefix = 5'd31;

  // one queue entry: a result plus a run of inferred followers, zero-valued but for chroma (1)
  typedef struct packed {
    logic [5:0]         id;
    logic [7:0]         idx;
    logic [3:0]         lst;
    logic signed [32:0] val;
    logic [1:0]         err;
    logic               last;
    logic [2:0]         extra;
  } token_t;

  typedef struct packed {
    logic       push;
    token_t     tok;
    logic       release_one;
    logic       flush;
  } fe_ctl_t;

  typedef struct packed {
    logic full;
  } be_status_t;

  typedef struct packed {
    logic [5:0]  pos;
    logic [4:0]  bitcnt;
    logic [4:0]  lzc;
    logic        suffix;
    logic [31:0] acc;
    logic [7:0]  profile;
    logic [1:0]  chroma;
    logic [3:0]  sln;
    logic [6:0]  sep;
    logic [7:0]  last_scale;
    logic [7:0]  clen;
    logic [7:0]  cpos;
    logic        stopped;
  } fe_state_t;

  function automatic fe_state_t fe_reset();
    fe_state_t s;
    s            = '0;
    s.chroma     = 2'd1;
    s.last_scale = 8'd8;
    s.stopped    = 1'b1;
    return s;
  endfunction

  function automatic logic [3:0] elem_kind(input logic [5:0] pos);
    logic [3:0] k;
    unique case (pos)
      6'd0, 6'd8: k = 4'd8;
      6'd7: k = 4'd2;
      6'd1, 6'd2, 6'd3, 6'd4, 6'd5, 6'd6, 6'd11, 6'd14, 6'd15, 6'd16, 6'd18,
      6'd22, 6'd28, 6'd31, 6'd32, 6'd33, 6'd34, 6'd39: k = 4'd1;
      6'd17, 6'd23, 6'd24, 6'd26: k = KIND_SE;
      default: k = KIND_UE;
    endcase
    return k;
  endfunction

  function automatic logic high_profile(input logic [7:0] p);
    return p == 8'd100 || p == 8'd110 || p == 8'd122 || p == 8'd244 || p == 8'd44 ||
           p == 8'd83 || p == 8'd86 || p == 8'd118 || p == 8'd128 || p == 8'd138 ||
           p == 8'd139 || p == 8'd134 || p == 8'd135;
  endfunction

endpackage

// File: hw/rtl/sps_if.sv
// Valid/ready channel interfaces for the SPS parser: bit input and element output.
// Depends on nothing.
interface sps_in_if;
  logic valid;
  logic ready;
  logic rbsp_bit;
  logic start_flag;
  modport source (output valid, rbsp_bit, start_flag, input ready);
  modport sink (input valid, rbsp_bit, start_flag, output ready);
endinterface

interface sps_out_if;
  logic               valid;
  logic               ready;
  logic [5:0]         element_id;
  logic [7:0]         element_index;
  logic [3:0]         list_number;
  logic signed [32:0] element_value;
  logic [1:0]         error_code;
  logic               last_flag;
  modport source (output valid, element_id, element_index, list_number, element_value,
                  error_code, last_flag, input ready);
  modport sink (input valid, element_id, element_index, list_number, element_value,
                error_code, last_flag, output ready);
endinterface

// File: hw/rtl/sps_front.sv
// Front end: takes one payload bit per item, decodes fields and queues tokens.
// Depends on sps_pkg and sps_if.
module sps_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [13:0]          cfg_data,
  sps_in_if.sink               in_ch,
  input  sps_pkg::be_status_t  st,
  output sps_pkg::fe_ctl_t     ctl
);

  logic [4:0]  max_ref;
  logic [9:0]  max_width;
  logic [9:0]  max_height;
  logic [13:0] max_crop_h;
  logic [13:0] max_crop_v;

  sps_pkg::fe_state_t state, state_next;
  logic [5:0] unrel, unrel_next;
  logic       accept;

  assign in_ch.ready = !st.full;
  assign accept      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_ref    <= 5'd16;
      max_width  <= 10'd511;
      max_height <= 10'd511;
      max_crop_h <= 14'd8192;
      max_crop_v <= 14'd8192;
    end else if (cfg_we) begin
      case (cfg_index)
        sps_pkg::CFG_MAX_REF:    max_ref    <= cfg_data[4:0];
        sps_pkg::CFG_MAX_WIDTH:  max_width  <= cfg_data[9:0];
        sps_pkg::CFG_MAX_HEIGHT: max_height <= cfg_data[9:0];
        sps_pkg::CFG_MAX_CROP_H: max_crop_h <= cfg_data;
        sps_pkg::CFG_MAX_CROP_V: max_crop_v <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sps_pkg::fe_reset();
      unrel <= '0;
    end else begin
      state <= state_next;
      unrel <= unrel_next;
    end
  end

  function automatic sps_pkg::token_t mk_tok(input logic [5:0] id, input logic [7:0] idx,
                                             input logic [3:0] lst,
                                             input logic signed [32:0] val,
                                             input logic [1:0] err, input logic last,
                                             input logic [2:0] extra);
    sps_pkg::token_t t;
    t.id = id; t.idx = idx; t.lst = lst; t.val = val;
    t.err = err; t.last = last; t.extra = extra;
    return t;
  endfunction

  always_comb begin
    sps_pkg::fe_state_t s;
    sps_pkg::token_t    tok;
    logic               push, fin, fin_eg, has_lim, next_list;
    logic [3:0]         kind;
    logic [5:0]         id;
    logic [32:0]        code;
    logic signed [32:0] v;
    logic [13:0]        lim;
    logic [7:0]         ns;
    logic [6:0]         sep_n;
    logic [7:0]         idx;
    logic [3:0]         lst;
    logic [6:0]         tot;

    s = state; tok = '0; push = 1'b0; fin = 1'b0; fin_eg = 1'b0; has_lim = 1'b0;
    next_list = 1'b0; code = '0; v = '0; lim = '0; ns = '0; sep_n = '0;
    idx = '0; lst = '0; tot = '0;
    id = s.pos; kind = sps_pkg::KIND_UE;

    if (accept && in_ch.start_flag) begin
      s = sps_pkg::fe_reset();
      s.stopped = 1'b0;
    end
    id   = s.pos;
    kind = sps_pkg::elem_kind(s.pos);

    if (accept && !s.stopped) begin
      if (s.pos >= sps_pkg::ID_COUNT) begin
        s.stopped = 1'b1;
      end else if (kind != sps_pkg::KIND_UE && kind != sps_pkg::KIND_SE) begin
        s.acc    = {s.acc[30:0], in_ch.rbsp_bit};
        s.bitcnt = s.bitcnt + 5'd1;
        if ({1'b0, s.bitcnt} >= {2'b0, kind}) begin
          fin = 1'b1;
          v   = $signed({1'b0, s.acc});
          s.acc = '0; s.bitcnt = '0;
        end
      end else if (!s.suffix) begin
        if (!in_ch.rbsp_bit) begin
          if (s.lzc >= sps_pkg::MaxPrefix) begin
            idx = (id == sps_pkg::ID_LIST_ENTRY) ? {1'b0, s.sep} :
                  ((id == sps_pkg::ID_OFFSET_REF) ? s.cpos : 8'd0);
            lst = (id == sps_pkg::ID_LIST_PRESENT || id == sps_pkg::ID_LIST_ENTRY) ?
                  s.sln : 4'd0;
            push = 1'b1;
            tok  = mk_tok(id, idx, lst, '0, sps_pkg::ERR_EXPGOLOMB, 1'b1, 3'd0);
            s.stopped = 1'b1;
          end else begin
            s.lzc = s.lzc + 5'd1;
          end
        end else if (s.lzc != 5'd0) begin
          s.suffix = 1'b1; s.acc = '0; s.bitcnt = '0;
        end else begin
          fin_eg = 1'b1;
        end
      end else begin
        s.acc    = {s.acc[30:0], in_ch.rbsp_bit};
        s.bitcnt = s.bitcnt + 5'd1;
        if (s.bitcnt >= s.lzc) begin
          fin_eg = 1'b1;
          code   = ((33'd1 << s.lzc) - 33'd1) + {1'b0, s.acc};
        end
      end

      if (fin_eg) begin
        s.acc = '0; s.bitcnt = '0; s.lzc = '0; s.suffix = 1'b0;
        fin = 1'b1;
        if (kind == sps_pkg::KIND_SE) begin
          // odd codes map to positive values, even codes to zero or negative ones
          v = code[0] ? $signed({1'b0, code[32:1]} + 33'd1) : -$signed({1'b0, code[32:1]});
        end else begin
          v = $signed(code);
        end
      end
    end

    if (fin) begin
      unique case (id)
        sps_pkg::ID_SPS_ID: begin has_lim = 1'b1; lim = 14'd31; end
        sps_pkg::ID_CHROMA: begin has_lim = 1'b1; lim = 14'd3; end
        sps_pkg::ID_BIT_DEPTH_L, sps_pkg::ID_BIT_DEPTH_C: begin
          has_lim = 1'b1; lim = 14'd6;
        end
        sps_pkg::ID_LOG2_FRAME, sps_pkg::ID_LOG2_POC: begin has_lim = 1'b1; lim = 14'd12; end
        sps_pkg::ID_POC_TYPE:   begin has_lim = 1'b1; lim = 14'd2; end
        sps_pkg::ID_POC_CYCLE:  begin has_lim = 1'b1; lim = 14'd255; end
        sps_pkg::ID_REF_FRAMES: begin has_lim = 1'b1; lim = {9'd0, max_ref}; end
        sps_pkg::ID_WIDTH:      begin has_lim = 1'b1; lim = {4'd0, max_width}; end
        sps_pkg::ID_HEIGHT:     begin has_lim = 1'b1; lim = {4'd0, max_height}; end
        sps_pkg::ID_CROP_LEFT, sps_pkg::ID_CROP_RIGHT: begin
          has_lim = 1'b1; lim = max_crop_h;
        end
        sps_pkg::ID_CROP_TOP, sps_pkg::ID_CROP_BOTTOM: begin
          has_lim = 1'b1; lim = max_crop_v;
        end
        default: ;
      endcase

      push = 1'b1;
      if (has_lim && v > $signed({19'd0, lim})) begin
        tok = mk_tok(id, 8'd0, 4'd0, v, sps_pkg::ERR_RANGE, 1'b1, 3'd0);
        s.stopped = 1'b1;
      end else if (id == sps_pkg::ID_LIST_PRESENT) begin
        tok = mk_tok(id, 8'd0, s.sln, v, sps_pkg::ERR_OK, 1'b0, 3'd0);
        if (v != 0) begin
          s.sep = '0; s.last_scale = 8'd8; s.pos = sps_pkg::ID_LIST_ENTRY;
        end else begin
          next_list = 1'b1;
        end
      end else if (id == sps_pkg::ID_LIST_ENTRY) begin
        if (v < -33'sd128 || v > 33'sd127) begin
          tok = mk_tok(id, {1'b0, s.sep}, s.sln, v, sps_pkg::ERR_DELTA, 1'b1, 3'd0);
          s.stopped = 1'b1;
        end else begin
          ns = s.last_scale + v[7:0];
          if (ns == 8'd0) begin
            // list ends by repeating the last value
            tok = mk_tok(sps_pkg::ID_LIST_FILL, {1'b0, s.sep}, s.sln,
                         $signed({25'd0, s.last_scale}), sps_pkg::ERR_OK, 1'b0, 3'd0);
            next_list = 1'b1;
          end else begin
            tok = mk_tok(id, {1'b0, s.sep}, s.sln, $signed({25'd0, ns}),
                         sps_pkg::ERR_OK, 1'b0, 3'd0);
            s.last_scale = ns;
            sep_n = s.sep + 7'd1;
            s.sep = sep_n;
            if (sep_n >= ((s.sln < 4'd6) ? 7'd16 : 7'd64)) next_list = 1'b1;
          end
        end
      end else if (id == sps_pkg::ID_OFFSET_REF) begin
        tok = mk_tok(id, s.cpos, 4'd0, v, sps_pkg::ERR_OK, 1'b0, 3'd0);
        s.cpos = s.cpos + 8'd1;
        if (s.cpos >= s.clen) s.pos = sps_pkg::ID_REF_FRAMES;
      end else begin
        tok = mk_tok(id, 8'd0, 4'd0, v, sps_pkg::ERR_OK, id == sps_pkg::ID_VUI_FLAG, 3'd0);
        s.pos = id + 6'd1;
        unique case (id)
          sps_pkg::ID_PROFILE: s.profile = v[7:0];
          sps_pkg::ID_SPS_ID: begin
            if (!sps_pkg::high_profile(s.profile)) begin
              s.chroma = 2'd1; tok.extra = 3'd6; s.pos = sps_pkg::ID_LOG2_FRAME;
            end
          end
          sps_pkg::ID_CHROMA: begin
            s.chroma = v[1:0];
            if (v[1:0] != 2'd3) begin
              tok.extra = 3'd1; s.pos = sps_pkg::ID_BIT_DEPTH_L;
            end
          end
          sps_pkg::ID_MATRIX_FLAG: begin
            s.sln = '0;
            s.pos = (v != 0) ? sps_pkg::ID_LIST_PRESENT : sps_pkg::ID_LOG2_FRAME;
          end
          sps_pkg::ID_POC_TYPE:
            s.pos = (v == 0) ? sps_pkg::ID_LOG2_POC :
                    ((v == 1) ? sps_pkg::ID_DELTA_ZERO : sps_pkg::ID_REF_FRAMES);
          sps_pkg::ID_LOG2_POC: s.pos = sps_pkg::ID_REF_FRAMES;
          sps_pkg::ID_POC_CYCLE: begin
            s.clen = v[7:0]; s.cpos = '0;
            s.pos = (v[7:0] != 8'd0) ? sps_pkg::ID_OFFSET_REF : sps_pkg::ID_REF_FRAMES;
          end
          sps_pkg::ID_FRAME_MBS: begin
            if (v != 0) begin
              tok.extra = 3'd1; s.pos = sps_pkg::ID_DIRECT_8X8;
            end
          end
          sps_pkg::ID_CROP_FLAG: begin
            if (v == 0) begin
              tok.extra = 3'd4; s.pos = sps_pkg::ID_VUI_FLAG;
            end
          end
          sps_pkg::ID_VUI_FLAG: s.stopped = 1'b1;
          default: ;
        endcase
      end

      if (next_list) begin
        s.sln = s.sln + 4'd1;
        s.pos = (s.sln < ((s.chroma == 2'd3) ? 4'd12 : 4'd8)) ?
                sps_pkg::ID_LIST_PRESENT : sps_pkg::ID_LOG2_FRAME;
      end
    end

    // the model releases one pending result per item
    tot = {1'b0, ((accept && in_ch.start_flag) ? 6'd0 : unrel)} +
          (push ? {3'd0, tok.extra} + 7'd1 : 7'd0);
    unrel_next      = unrel;
    ctl.release_one = 1'b0;
    if (accept) begin
      if (tot != 7'd0) begin
        ctl.release_one = 1'b1;
        unrel_next      = 6'(tot - 7'd1);
      end else begin
        unrel_next = '0;
      end
    end

    ctl.push   = push;
    ctl.tok    = tok;
    ctl.flush  = accept && in_ch.start_flag;
    state_next = s;
  end

endmodule

// File: hw/rtl/sps_back.sv
// Back end: token queue, expansion of inferred elements and the output register.
// Depends on sps_pkg and sps_if.
module sps_back (
  input  logic                 clk,
  input  logic                 rst,
  input  sps_pkg::fe_ctl_t     ctl,
  output sps_pkg::be_status_t  st,
  sps_out_if.source            out_ch
);

  sps_pkg::token_t mem [sps_pkg::QDepth];

  logic [sps_pkg::QPtrW-1:0] wr, rd;
  logic [sps_pkg::QPtrW:0]   count, count_next, old_tokens, old_tokens_next;
  logic [2:0]                k, k_next;
  logic [7:0]                credit, credit_next, old_credit, old_credit_next;
  logic                      ovalid, ovalid_next;
  logic                      deliver, drop, pop, is_old, ov_free;
  sps_pkg::token_t           head;
  logic [5:0]                cur_id;

  logic [5:0]         o_id;
  logic [7:0]         o_idx;
  logic [3:0]         o_lst;
  logic signed [32:0] o_val;
  logic [1:0]         o_err;
  logic               o_last;

  assign st.full = (count == (sps_pkg::QPtrW + 1)'(sps_pkg::QDepth));
  assign head    = mem[rd];
  assign cur_id  = head.id + {3'd0, k};
  assign is_old  = (old_tokens != '0);
  assign ov_free = !ovalid || out_ch.ready;
  assign deliver = (count != '0) && (credit != 8'd0) && (!is_old || old_credit != 8'd0) &&
                   ov_free;
  // a stale item from an abandoned parse with nothing released is dropped whole
  assign drop    = (count != '0) && is_old && (old_credit == 8'd0);
  assign pop     = drop || (deliver && k == head.extra);

  always_comb begin
    logic [sps_pkg::QPtrW:0] cnt_pop;
    logic [7:0]              cred_pop;

    cnt_pop  = count - (pop ? (sps_pkg::QPtrW + 1)'(1) : '0);
    cred_pop = credit - (deliver ? 8'd1 : 8'd0);

    k_next          = pop ? 3'd0 : (deliver ? k + 3'd1 : k);
    old_tokens_next = old_tokens - ((pop && is_old) ? (sps_pkg::QPtrW + 1)'(1) : '0);
    old_credit_next = old_credit - ((deliver && is_old) ? 8'd1 : 8'd0);
    if (ctl.flush) begin
      old_tokens_next = cnt_pop;
      old_credit_next = cred_pop;
    end
    count_next  = cnt_pop + (ctl.push ? (sps_pkg::QPtrW + 1)'(1) : '0);
    credit_next = cred_pop + (ctl.release_one ? 8'd1 : 8'd0);
    ovalid_next = deliver ? 1'b1 : (out_ch.ready ? 1'b0 : ovalid);
  end

  always_ff @(posedge clk) begin
    if (ctl.push) mem[wr] <= ctl.tok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr <= '0; rd <= '0; count <= '0; k <= '0; credit <= '0;
      old_tokens <= '0; old_credit <= '0; ovalid <= 1'b0;
    end else begin
      if (ctl.push) wr <= wr + 1'b1;
      if (pop) rd <= rd + 1'b1;
      count      <= count_next;
      k          <= k_next;
      credit     <= credit_next;
      old_tokens <= old_tokens_next;
      old_credit <= old_credit_next;
      ovalid     <= ovalid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (deliver) begin
      if (k == 3'd0) begin
        o_id <= head.id; o_idx <= head.idx; o_lst <= head.lst;
        o_val <= head.val; o_err <= head.err; o_last <= head.last;
      end else begin
        o_id <= cur_id; o_idx <= '0; o_lst <= '0;
        o_val <= (cur_id == sps_pkg::ID_CHROMA) ? 33'sd1 : 33'sd0;
        o_err <= sps_pkg::ERR_OK; o_last <= 1'b0;
      end
    end
  end

  assign out_ch.valid         = ovalid;
  assign out_ch.element_id    = o_id;
  assign out_ch.element_index = o_idx;
  assign out_ch.list_number   = o_lst;
  assign out_ch.element_value = o_val;
  assign out_ch.error_code    = o_err;
  assign out_ch.last_flag     = o_last;

endmodule

// File: hw/rtl/h264_sps_syntax_parser.sv
// Top level of the H.264 SPS syntax parser: front end, back end, channels.
// Depends on sps_pkg, sps_if, sps_front and sps_back.
//
// Usage: feed the SPS payload on in_ch, one bit per item, most significant
// first, with start_flag set on the first bit. Each decoded or inferred
// syntax element leaves on out_ch as one item; the last one (or an error
// item) carries last_flag. Limits are written on cfg_* while idle.
// Throughput: one bit per cycle while the token queue has room. The item of
// an element passes through the token queue and the output register. Inferred
// elements leave one per later accepted bit, so keep feeding bits (for
// example the trailing bits) to collect them.
// An 8-entry token queue sits between the decoder and the output
// register; in_ch.ready drops only when that queue is full, which happens
// when out_ch is stalled for several items.
// Reset: parser idle until a start bit, queue and output empty, limits at
// their defaults. A start bit abandons the current parse and discards
// results that have not yet been released.
module h264_sps_syntax_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [13:0] cfg_data,
  sps_in_if.sink      in_ch,
  sps_out_if.source   out_ch
);

  sps_pkg::fe_ctl_t    ctl;
  sps_pkg::be_status_t st;

  sps_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .st        (st),
    .ctl       (ctl)
  );

  sps_back u_back (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .st     (st),
    .out_ch (out_ch)
  );

endmodule

// File: hw/rtl/sps_checker.sv
// Port-level checks for the SPS parser, bound to the top level.
// Depends on sps_pkg.
module sps_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [5:0] out_id,
  input logic [1:0] out_err,
  input logic       out_last
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output item withdrawn while stalled");

  a_err_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_err != sps_pkg::ERR_OK |-> out_last)
    else $error("error item without last flag");

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_id_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_id < sps_pkg::ID_COUNT)
    else $error("element id out of range");

endmodule

bind h264_sps_syntax_parser sps_checker u_chk (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_id    (out_ch.element_id),
  .out_err   (out_ch.error_code),
  .out_last  (out_ch.last_flag)
);

// File: test/sps_tb_if.sv
// Channel item types as the bench sees them: re-exports nothing, only defines structs for
// one output element and one input payload bit. Depends on sps_pkg.
package sps_tb_types;
  import sps_pkg::*;

  // one element as it leaves the parser
  typedef struct {
    logic [5:0]         id;
    logic [7:0]         idx;
    logic [3:0]         lst;
    logic signed [32:0] val;
    logic [1:0]         err;
    logic               last;
  } elem_t;

  // one payload bit on its way in
  typedef struct {
    bit b;
    bit s;
  } rbsp_item_t;
endpackage

// File: test/tb_h264_sps_syntax_parser.sv
// Self-checking bench for h264_sps_syntax_parser: random SPS bitstreams in, decoded
// elements compared against a bit-serial predictor. Depends on sps_pkg, sps_if, sps_tb_types.
module tb_h264_sps_syntax_parser;
  import sps_pkg::*;
  import sps_tb_types::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int FIFO_DEPTH   = 16;
  localparam int GOL_UE       = KIND_UE;
  localparam int GOL_SE       = KIND_SE;
  localparam int ID_SEP_PLANE = 11;
  localparam int ID_BYPASS    = 14;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [13:0] cfg_data;

  sps_in_if  bits_ch ();
  sps_out_if elems_ch ();

  h264_sps_syntax_parser dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_ch(bits_ch), .out_ch(elems_ch)
  );

  always #10 clk = ~clk;

  // bits per fixed element, else golomb kind
  int kind_tbl[40] = '{8, 1, 1, 1, 1, 1, 1, 2, 8, GOL_UE,
                       GOL_UE, 1, GOL_UE, GOL_UE, 1, 1, 1, GOL_SE, 1, GOL_UE,
                       GOL_UE, GOL_UE, 1, GOL_SE, GOL_SE, GOL_UE, GOL_SE, GOL_UE, 1, GOL_UE,
                       GOL_UE, 1, 1, 1, 1, GOL_UE, GOL_UE, GOL_UE, GOL_UE, 1};

  rbsp_item_t bit_q[$];
  elem_t      held_elems[$];   // decoded but not yet released
  elem_t      due_elems[$];    // released, awaiting the output
  longint     lim_tbl[5];
  int n_bad, cycles, send_idle_pct, stall_pct;

  // parser state
  int p_pos, p_bits, p_zeros, p_profile, p_chroma, p_list, p_entry;
  int p_last, p_next, p_cyc_len, p_cyc_pos;
  bit p_suffix, p_halted;
  longint p_acc;

  // generator state
  bit start_next, broken, trip;

  function automatic bit is_high(int p);
    case (p)
      100, 110, 122, 244, 44, 83, 86, 118, 128, 138, 139, 134, 135: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic void queue_elem(int id, int idx, int lst, longint v, logic [1:0] err,
                                     bit last);
    elem_t e;
    if (held_elems.size() >= FIFO_DEPTH) return;
    e.id = id[5:0]; e.idx = idx[7:0]; e.lst = lst[3:0];
    e.val = v[32:0]; e.err = err; e.last = last;
    held_elems.push_back(e);
  endfunction

  function automatic void abort_parse(int id, int idx, int lst, longint v, logic [1:0] err);
    queue_elem(id, idx, lst, v, err, 1'b1);
    p_halted = 1'b1;
  endfunction

  function automatic void clear_parse();
    p_pos = 0; p_bits = 0; p_zeros = 0; p_acc = 0; p_suffix = 0;
    p_profile = 0; p_chroma = 1; p_list = 0; p_entry = 0;
    p_last = 8; p_next = 8; p_cyc_len = 0; p_cyc_pos = 0;
  endfunction

  function automatic void next_list();
    p_list++;
    p_pos = (p_list < (p_chroma == 3 ? 12 : 8)) ? ID_LIST_PRESENT : ID_LOG2_FRAME;
  endfunction

  function automatic void close_elem(int id, longint v);
    longint lim;
    int size;
    lim = -1;
    case (id)
      ID_PROFILE: p_profile = v & 255;
      ID_SPS_ID: lim = 31;
      ID_CHROMA: lim = 3;
      ID_BIT_DEPTH_L, ID_BIT_DEPTH_C: lim = 6;
      ID_LOG2_FRAME, ID_LOG2_POC: lim = 12;
      ID_POC_TYPE: lim = 2;
      ID_POC_CYCLE: lim = 255;
      ID_REF_FRAMES: lim = lim_tbl[CFG_MAX_REF];
      ID_WIDTH: lim = lim_tbl[CFG_MAX_WIDTH];
      ID_HEIGHT: lim = lim_tbl[CFG_MAX_HEIGHT];
      ID_CROP_LEFT, ID_CROP_RIGHT: lim = lim_tbl[CFG_MAX_CROP_H];
      ID_CROP_TOP, ID_CROP_BOTTOM: lim = lim_tbl[CFG_MAX_CROP_V];
      default: ;
    endcase
    if (lim >= 0 && v > lim) begin
      abort_parse(id, 0, 0, v, ERR_RANGE);
      return;
    end
    if (id == ID_LIST_PRESENT) begin
      queue_elem(ID_LIST_PRESENT, 0, p_list, v, ERR_OK, 0);
      if (v != 0) begin
        p_entry = 0; p_last = 8; p_next = 8; p_pos = ID_LIST_ENTRY;
      end else next_list();
      return;
    end
    if (id == ID_LIST_ENTRY) begin
      if (v < -128 || v > 127) begin
        abort_parse(ID_LIST_ENTRY, p_entry, p_list, v, ERR_DELTA);
        return;
      end
      p_next = (p_last + v + 256) & 255;
      size = p_list < 6 ? 16 : 64;
      if (p_next == 0) begin
        // list stops here: remaining entries repeat the last scale
        queue_elem(ID_LIST_FILL, p_entry, p_list, p_last, ERR_OK, 0);
        next_list();
      end else begin
        queue_elem(ID_LIST_ENTRY, p_entry, p_list, p_next, ERR_OK, 0);
        p_last = p_next;
        p_entry++;
        if (p_entry >= size) next_list();
      end
      return;
    end
    if (id == ID_OFFSET_REF) begin
      queue_elem(ID_OFFSET_REF, p_cyc_pos, 0, v, ERR_OK, 0);
      p_cyc_pos++;
      if (p_cyc_pos >= p_cyc_len) p_pos = ID_REF_FRAMES;
      return;
    end
    queue_elem(id, 0, 0, v, ERR_OK, id == ID_VUI_FLAG);
    case (id)
      ID_SPS_ID: begin
        if (is_high(p_profile)) p_pos = ID_CHROMA;
        else begin
          p_chroma = 1;
          queue_elem(ID_CHROMA, 0, 0, 1, ERR_OK, 0);
          queue_elem(ID_SEP_PLANE, 0, 0, 0, ERR_OK, 0);
          queue_elem(ID_BIT_DEPTH_L, 0, 0, 0, ERR_OK, 0);
          queue_elem(ID_BIT_DEPTH_C, 0, 0, 0, ERR_OK, 0);
          queue_elem(ID_BYPASS, 0, 0, 0, ERR_OK, 0);
          queue_elem(ID_MATRIX_FLAG, 0, 0, 0, ERR_OK, 0);
          p_pos = ID_LOG2_FRAME;
        end
      end
      ID_CHROMA: begin
        p_chroma = v & 3;
        if (v == 3) p_pos = ID_SEP_PLANE;
        else begin
          queue_elem(ID_SEP_PLANE, 0, 0, 0, ERR_OK, 0);
          p_pos = ID_BIT_DEPTH_L;
        end
      end
      ID_MATRIX_FLAG: begin
        p_list = 0;
        p_pos = v != 0 ? ID_LIST_PRESENT : ID_LOG2_FRAME;
      end
      ID_POC_TYPE: p_pos = v == 0 ? ID_LOG2_POC : (v == 1 ? ID_DELTA_ZERO : ID_REF_FRAMES);
      ID_LOG2_POC: p_pos = ID_REF_FRAMES;
      ID_POC_CYCLE: begin
        p_cyc_len = v & 255; p_cyc_pos = 0;
        p_pos = p_cyc_len != 0 ? ID_OFFSET_REF : ID_REF_FRAMES;
      end
      ID_FRAME_MBS: begin
        if (v != 0) begin
          queue_elem(ID_MBAFF, 0, 0, 0, ERR_OK, 0);
          p_pos = ID_DIRECT_8X8;
        end else p_pos = ID_MBAFF;
      end
      ID_CROP_FLAG: begin
        if (v != 0) p_pos = ID_CROP_LEFT;
        else begin
          queue_elem(ID_CROP_LEFT, 0, 0, 0, ERR_OK, 0);
          queue_elem(ID_CROP_RIGHT, 0, 0, 0, ERR_OK, 0);
          queue_elem(ID_CROP_TOP, 0, 0, 0, ERR_OK, 0);
          queue_elem(ID_CROP_BOTTOM, 0, 0, 0, ERR_OK, 0);
          p_pos = ID_VUI_FLAG;
        end
      end
      ID_VUI_FLAG: p_halted = 1'b1;
      default: p_pos = id + 1;
    endcase
  endfunction

  function automatic void take_bit(bit b);
    int k;
    longint code;
    if (p_pos >= ID_COUNT) begin
      p_halted = 1'b1;
      return;
    end
    k = kind_tbl[p_pos];
    if (k >= 1 && k <= 8) begin
      p_acc = (p_acc << 1) | b;
      p_bits++;
      if (p_bits >= k) begin
        code = p_acc; p_acc = 0; p_bits = 0;
        close_elem(p_pos, code);
      end
      return;
    end
    if (!p_suffix) begin
      if (b == 0) begin
        if (p_zeros >= MaxPrefix)
          abort_parse(p_pos, p_pos == ID_LIST_ENTRY ? p_entry :
                             (p_pos == ID_OFFSET_REF ? p_cyc_pos : 0),
                      (p_pos == ID_LIST_PRESENT || p_pos == ID_LIST_ENTRY) ? p_list : 0,
                      0, ERR_EXPGOLOMB);
        else p_zeros++;
        return;
      end
      if (p_zeros != 0) begin
        p_suffix = 1; p_acc = 0; p_bits = 0;
        return;
      end
      code = 0;
    end else begin
      p_acc = (p_acc << 1) | b;
      p_bits++;
      if (p_bits < p_zeros) return;
      code = ((64'd1 << p_zeros) - 1) + p_acc;
    end
    p_acc = 0; p_bits = 0; p_zeros = 0; p_suffix = 0;
    if (k == GOL_SE) close_elem(p_pos, code[0] ? (code + 1) >>> 1 : -(code >>> 1));
    else close_elem(p_pos, code);
  endfunction

  // one accepted bit: decode, then release at most one element
  function automatic void step_parser(bit b, bit s);
    if (s) begin
      clear_parse();
      p_halted = 1'b0;
      held_elems.delete();
    end
    if (!p_halted) take_bit(b);
    if (held_elems.size() > 0) due_elems.push_back(held_elems.pop_front());
  endfunction

  // ---------------- stimulus helpers ----------------
  task automatic add_bit(bit b);
    rbsp_item_t it;
    if (broken) return;
    it.b = b; it.s = start_next;
    start_next = 0;
    bit_q.push_back(it);
  endtask

  task automatic put_fix(longint v, int n);
    for (int i = n - 1; i >= 0; i--) add_bit(v[i]);
  endtask

  task automatic put_ue(longint v);
    longint c;
    int n;
    c = v + 1;
    n = 0;
    if ($urandom_range(79) == 0) begin
      put_fix(0, 32);   // prefix too long
      broken = 1;
      return;
    end
    while ((c >> n) > 1) n++;
    put_fix(0, n);
    put_fix(c, n + 1);
    if (trip) broken = 1;
    trip = 0;
  endtask

  task automatic put_se(longint v);
    put_ue(v > 0 ? 2 * v - 1 : -2 * v);
  endtask

  function automatic longint rnd_lim(longint hi);
    if ($urandom_range(29) == 0) begin
      trip = 1;
      return hi + 1 + $urandom_range(7);
    end
    if ($urandom_range(7) == 0) return hi;
    return $urandom_range(0, hi < 20 ? hi : 20);
  endfunction

  function automatic longint rnd_se();
    case ($urandom_range(19))
      0: return 64'sd2147483647;
      1: return -64'sd2147483647;
      default: return longint'($urandom_range(40)) - 20;
    endcase
  endfunction

  task automatic trailer();
    broken = 0;
    start_next = 0;
    put_fix(16'h8000, 16);
  endtask

  task automatic gen_list(int size);
    int last, d, nxt;
    last = 8;
    for (int j = 0; j < size; j++) begin
      case ($urandom_range(11))
        0: d = last > 128 ? 256 - last : -last;
        1: d = $urandom_range(1) ? 127 : -128;
        2: d = ($urandom_range(9) == 0) ? 128 + $urandom_range(60) : $urandom_range(40) - 20;
        default: d = $urandom_range(40) - 20;
      endcase
      put_se(d);
      if (d < -128 || d > 127) broken = 1;
      if (broken) return;
      nxt = (last + d + 256) & 255;
      if (nxt == 0) return;
      last = nxt;
    end
  endtask

  task automatic gen_sps(int want_prof);
    int prof, chroma, poc, n;
    bit m, f;
    int hp[13] = '{100, 110, 122, 244, 44, 83, 86, 118, 128, 138, 139, 134, 135};
    start_next = 1; broken = 0; trip = 0;
    if (want_prof >= 0) prof = want_prof;
    else prof = $urandom_range(1) ? hp[$urandom_range(12)] : $urandom_range(255);
    put_fix(prof, 8);
    put_fix($urandom, 8);
    put_fix($urandom, 8);
    put_ue(rnd_lim(31));
    chroma = 1;
    if (is_high(prof)) begin
      chroma = rnd_lim(3);
      put_ue(chroma);
      if (chroma == 3) put_fix($urandom, 1);
      put_ue(rnd_lim(6));
      put_ue(rnd_lim(6));
      put_fix($urandom, 1);
      m = $urandom_range(2) == 0;
      put_fix(m, 1);
      if (m)
        for (int l = 0; l < (chroma == 3 ? 12 : 8); l++) begin
          f = $urandom_range(2) == 0;
          put_fix(f, 1);
          if (f) gen_list(l < 6 ? 16 : 64);
        end
    end
    put_ue(rnd_lim(12));
    poc = rnd_lim(2);
    put_ue(poc);
    if (poc == 0) put_ue(rnd_lim(12));
    else if (poc == 1) begin
      put_fix($urandom, 1);
      put_se(rnd_se());
      put_se(rnd_se());
      n = ($urandom_range(15) == 0) ? 256 : $urandom_range(4);
      put_ue(n);
      for (int i = 0; i < n && i < 255; i++) put_se(rnd_se());
    end
    put_ue(rnd_lim(lim_tbl[CFG_MAX_REF]));
    put_fix($urandom, 1);
    put_ue(rnd_lim(lim_tbl[CFG_MAX_WIDTH]));
    put_ue(rnd_lim(lim_tbl[CFG_MAX_HEIGHT]));
    f = $urandom;
    put_fix(f, 1);
    if (!f) put_fix($urandom, 1);
    put_fix($urandom, 1);
    f = $urandom;
    put_fix(f, 1);
    if (f) begin
      put_ue(rnd_lim(lim_tbl[CFG_MAX_CROP_H]));
      put_ue(rnd_lim(lim_tbl[CFG_MAX_CROP_H]));
      put_ue(rnd_lim(lim_tbl[CFG_MAX_CROP_V]));
      put_ue(rnd_lim(lim_tbl[CFG_MAX_CROP_V]));
    end
    put_fix($urandom, 1);
    trailer();
  endtask

  task automatic gen_noise();
    start_next = $urandom_range(1);
    broken = 0;
    put_fix({$urandom, $urandom}, $urandom_range(3, 40));
    trailer();
  endtask

  task automatic fill_random(int n_bits);
    int stop_at;
    stop_at = bit_q.size() + n_bits;
    while (bit_q.size() < stop_at)
      if ($urandom_range(9) == 0) gen_noise();
      else gen_sps(-1);
  endtask

  task automatic wait_drained();
    while (bit_q.size() > 0 || bits_ch.valid || due_elems.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, longint v);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= v[13:0];
    lim_tbl[idx] = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_all(longint r, longint w, longint h, longint ch, longint cv);
    write_reg(CFG_MAX_REF, r);
    write_reg(CFG_MAX_WIDTH, w);
    write_reg(CFG_MAX_HEIGHT, h);
    write_reg(CFG_MAX_CROP_H, ch);
    write_reg(CFG_MAX_CROP_V, cv);
  endtask

  task automatic note_bad(string what, elem_t want, bit have_want);
    n_bad++;
    if (n_bad <= 10) begin
      if (have_want)
        $display("%s: exp id=%0d idx=%0d lst=%0d val=%0d err=%0d last=%0d", what,
                 want.id, want.idx, want.lst, want.val, want.err, want.last);
      $display("%s: got id=%0d idx=%0d lst=%0d val=%0d err=%0d last=%0d", what,
               elems_ch.element_id, elems_ch.element_index, elems_ch.list_number,
               elems_ch.element_value, elems_ch.error_code, elems_ch.last_flag);
    end
  endtask

  // ---------------- driver ----------------
  always @(posedge clk) begin : drive_bits
    rbsp_item_t it;
    if (rst) bits_ch.valid <= 1'b0;
    else begin
      if (bits_ch.valid && bits_ch.ready) step_parser(bits_ch.rbsp_bit, bits_ch.start_flag);
      if (!bits_ch.valid || bits_ch.ready) begin
        if (bit_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          it = bit_q.pop_front();
          bits_ch.valid      <= 1'b1;
          bits_ch.rbsp_bit   <= it.b;
          bits_ch.start_flag <= it.s;
        end else bits_ch.valid <= 1'b0;
      end
    end
  end

  // ---------------- monitor ----------------
  always @(posedge clk) begin : watch_elems
    elem_t want;
    if (rst) elems_ch.ready <= 1'b0;
    else begin
      if (elems_ch.valid && elems_ch.ready) begin
        if (due_elems.size() == 0) note_bad("unexpected item", want, 0);
        else begin
          want = due_elems.pop_front();
          if (elems_ch.element_id !== want.id || elems_ch.element_index !== want.idx ||
              elems_ch.list_number !== want.lst || elems_ch.element_value !== want.val ||
              elems_ch.error_code !== want.err || elems_ch.last_flag !== want.last)
            note_bad("mismatch", want, 1);
        end
      end
      elems_ch.ready <= $urandom_range(99) >= stall_pct;
    end
  end

  always @(posedge clk) begin : watchdog
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("h264_sps_syntax_parser verification failed");
      $finish;
    end
  end

  initial begin
    bits_ch.valid = 1'b0; bits_ch.rbsp_bit = 1'b0; bits_ch.start_flag = 1'b0;
    elems_ch.ready = 1'b0;
    cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    send_idle_pct = 0; stall_pct = 0;
    n_bad = 0; cycles = 0;
    lim_tbl = '{16, 511, 511, 8192, 8192};
    clear_parse();
    p_halted = 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: bits while idle, overlong code, largest ue, broken start, both profile kinds
    start_next = 0; broken = 0; trip = 0;
    put_fix(8'hA5, 8);
    start_next = 1;
    put_fix(66, 8); put_fix(0, 16); put_fix(0, 32);
    trailer();
    start_next = 1;
    put_fix(77, 8); put_fix(16'hFFFF, 16); put_fix(0, 31); put_fix(64'hFFFFFFFF, 32);
    trailer();
    start_next = 1;
    put_fix(100, 8); put_fix(24'h3C5A1, 20);
    gen_sps(100);
    gen_sps(66);
    wait_drained();

    // phase: limits at their lowest, no idling
    write_all(0, 0, 0, 0, 0);
    fill_random(120);
    wait_drained();

    write_all(16, 1023, 1023, 16383, 16383);
    send_idle_pct = 72;
    fill_random(70);
    wait_drained();   // sender holds off until everything has come out
    fill_random(70);
    wait_drained();

    write_all($urandom_range(16), $urandom_range(1023), $urandom_range(1023),
              $urandom_range(16383), $urandom_range(16383));
    send_idle_pct = 0; stall_pct = 72;
    fill_random(140);
    wait_drained();

    write_all(16, 511, 511, 8192, 8192);
    send_idle_pct = 30; stall_pct = 30;
    fill_random(140);
    wait_drained();

    repeat (20) @(posedge clk);
    if (n_bad == 0) $display("h264_sps_syntax_parser verification clean");
    else $display("h264_sps_syntax_parser verification failed");
    $finish;
  end

endmodule

// File: h264_sps_syntax_parser.f
hw/rtl/sps_pkg.sv
hw/rtl/sps_if.sv
hw/rtl/sps_front.sv
hw/rtl/sps_back.sv
hw/rtl/h264_sps_syntax_parser.sv
hw/rtl/sps_checker.sv
test/sps_tb_if.sv
test/tb_h264_sps_syntax_parser.sv
